// ----- rtl/rtts_pkg.sv -----
package rtts_pkg;

    localparam int DefTaskSlots      = 16;
    localparam int DefTimerSlots     = 8;
    localparam int DefIdleIndex      = 0;
    localparam int DefLowestPriority = 255;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SCHED  = 2'd1,
        OP_WTASK  = 2'd2,
        OP_WTIMER = 2'd3
    } t_op;

    localparam logic [2:0] TS_UNUSED = 3'd0;
    localparam logic [2:0] TS_INIT   = 3'd1;
    localparam logic [2:0] TS_READY  = 3'd2;
    localparam logic [2:0] TS_RUN    = 3'd3;
    localparam logic [2:0] TS_PEND   = 3'd4;

    localparam logic [1:0] TM_INIT = 2'd0;
    localparam logic [1:0] TM_STOP = 2'd1;
    localparam logic [1:0] TM_RUN  = 2'd3;

    localparam logic [1:0] PK_NONE  = 2'd0;
    localparam logic [1:0] PK_SLEEP = 2'd1;

    localparam logic [1:0] RK_ACK    = 2'd0;
    localparam logic [1:0] RK_FIRED  = 2'd1;
    localparam logic [1:0] RK_WOKEN  = 2'd2;
    localparam logic [1:0] RK_SWITCH = 2'd3;

    localparam logic CFG_RUN_ENABLE    = 1'b0;
    localparam logic CFG_REFILL_PERIOD = 1'b1;

endpackage

// ----- rtl/rtos_tick_task_scheduler.sv -----
// rtos tick task scheduler
// input channel: i_in_valid / o_in_stall carry one transaction per operation
// (tick, schedule, write task slot, write timer slot). output channel:
// o_out_valid / i_out_stall carry result transactions; o_last marks the final
// result of an operation. the input side is stalled while an operation runs.
// a write registers its slot, then acks. a schedule walks all task slots once,
// then switches through S_CH1 (and S_CH2 on a tick) to S_CH3, or acks when
// the pick is the current task. a tick walks all timers, then all pend waits,
// then refills the budgets of live tasks on a refill tick, then runs the
// schedule walk. task table accesses go through one slot index and timer
// accesses through another, so the walks are set by slot count.
// a result that cannot be handed over because the receiver stalls holds the
// walk in place until the output register frees up.
// reset (synchronous, active low) clears every task to unused, timers to
// init, the refill counter to zero and selects the idle task; run_enable
// comes up 0, so tick and schedule only report the current task.
// config: i_cfg_we with i_cfg_index 0 run_enable, 1 refill_period.
module rtos_tick_task_scheduler
    import rtts_pkg::*;
#(
    parameter int TASK_SLOTS      = DefTaskSlots,
    parameter int TIMER_SLOTS     = DefTimerSlots,
    parameter int IDLE_INDEX      = DefIdleIndex,
    parameter int LOWEST_PRIORITY = DefLowestPriority
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_entry_index,
    input  logic [2:0]  i_new_state,
    input  logic [7:0]  i_priority_value,
    input  logic [15:0] i_weight_value,
    input  logic [1:0]  i_pend_kind,
    input  logic [31:0] i_count_value,
    input  logic [15:0] i_repeat_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [3:0]  o_result_index,
    output logic        o_timed_out,
    output logic        o_last
);

    localparam int TW = $clog2(TASK_SLOTS);
    localparam int MW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [TW-1:0] IDLE_SLOT =
        TW'((IDLE_INDEX < TASK_SLOTS) ? IDLE_INDEX : 0);
    localparam logic [TW-1:0] LAST_TASK  = TW'(TASK_SLOTS - 1);
    localparam logic [MW-1:0] LAST_TIMER = MW'(TIMER_SLOTS - 1);
    localparam logic [7:0]    LOW_PRI    = 8'(LOWEST_PRIORITY);

    typedef enum logic [3:0] {
        S_IDLE, S_WTASK, S_WTIMER, S_ACK, S_TMR, S_TSK, S_RFL,
        S_PICK, S_CH1, S_CH2, S_CH3
    } t_state;

    t_state r_state;

    logic        r_run_en;
    logic [15:0] r_period;
    logic [15:0] r_refill_cnt;

    logic [2:0]  r_status [TASK_SLOTS];
    logic [7:0]  r_pri    [TASK_SLOTS];
    logic [15:0] r_weight [TASK_SLOTS];
    logic [15:0] r_budget [TASK_SLOTS];
    logic [1:0]  r_wkind  [TASK_SLOTS];
    logic [31:0] r_wticks [TASK_SLOTS];
    logic        r_tflag  [TASK_SLOTS];

    logic [1:0]  r_tm_status [TIMER_SLOTS];
    logic [15:0] r_tm_rep    [TIMER_SLOTS];
    logic [31:0] r_tm_cnt    [TIMER_SLOTS];
    logic [31:0] r_tm_rld    [TIMER_SLOTS];

    logic [TW-1:0] r_cur, r_ti, r_nx, r_best, r_best0;
    logic [7:0]    r_bpri, r_bpri0;
    logic [MW-1:0] r_mi;
    logic          r_tick, r_in_range;
    logic [3:0]    r_ack_idx;

    logic [2:0]  r_in_state;
    logic [7:0]  r_in_pri;
    logic [15:0] r_in_weight;
    logic [1:0]  r_in_pend;
    logic [31:0] r_in_count;
    logic [15:0] r_in_repeat;

    logic        r_ov;
    logic [1:0]  r_kind;
    logic [3:0]  r_idx;
    logic        r_to, r_last;

    logic          in_take, out_take, can_out, elig;
    logic [TW-1:0] n_best, n_best0;
    logic [7:0]    n_bpri, n_bpri0;

    assign o_in_stall     = (r_state != S_IDLE);
    assign in_take        = i_in_valid && !o_in_stall;
    assign out_take       = r_ov && !i_out_stall;
    assign can_out        = !r_ov || !i_out_stall;
    assign o_out_valid    = r_ov;
    assign o_result_kind  = r_kind;
    assign o_result_index = r_idx;
    assign o_timed_out    = r_to;
    assign o_last         = r_last;

    // running best picks including the slot under the walk index
    always_comb begin
        n_best  = r_best;
        n_bpri  = r_bpri;
        n_best0 = r_best0;
        n_bpri0 = r_bpri0;
        elig    = (r_status[r_ti] == TS_READY) || (r_status[r_ti] == TS_RUN);
        if (elig) begin
            if (r_budget[r_ti] != 16'd0) begin
                if (r_pri[r_ti] < r_bpri) begin
                    n_bpri = r_pri[r_ti];
                    n_best = r_ti;
                end
            end else if (r_pri[r_ti] < r_bpri0) begin
                n_bpri0 = r_pri[r_ti];
                n_best0 = r_ti;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run_en     <= 1'b0;
            r_period     <= 16'd0;
            r_refill_cnt <= 16'd0;
            r_cur        <= IDLE_SLOT;
            r_ov         <= 1'b0;
            r_ti         <= '0;
            r_mi         <= '0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                r_status[i] <= TS_UNUSED;
                r_budget[i] <= 16'd0;
                r_wkind[i]  <= PK_NONE;
                r_wticks[i] <= 32'd0;
                r_tflag[i]  <= 1'b0;
            end
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                r_tm_status[i] <= TM_INIT;
                r_tm_rep[i]    <= 16'd0;
                r_tm_cnt[i]    <= 32'd0;
                r_tm_rld[i]    <= 32'd0;
            end
        end else begin
            logic n_ov;
            // output register empties on a handoff unless reloaded below
            n_ov = r_ov && !out_take;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RUN_ENABLE) begin
                    r_run_en <= i_cfg_data[0];
                end else begin
                    r_period <= i_cfg_data;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_in_state  <= i_new_state;
                        r_in_pri    <= i_priority_value;
                        r_in_weight <= i_weight_value;
                        r_in_pend   <= i_pend_kind;
                        r_in_count  <= i_count_value;
                        r_in_repeat <= i_repeat_count;
                        unique case (t_op'(i_operation))
                            OP_WTASK: begin
                                r_ack_idx  <= i_entry_index;
                                r_in_range <= 32'(i_entry_index) < TASK_SLOTS;
                                r_ti       <= TW'(i_entry_index);
                                r_state    <= S_WTASK;
                            end
                            OP_WTIMER: begin
                                r_ack_idx  <= i_entry_index;
                                r_in_range <= 32'(i_entry_index) < TIMER_SLOTS;
                                r_mi       <= MW'(i_entry_index);
                                r_state    <= S_WTIMER;
                            end
                            OP_TICK, OP_SCHED: begin
                                if (!r_run_en) begin
                                    r_ack_idx <= 4'(r_cur);
                                    r_state   <= S_ACK;
                                end else if (t_op'(i_operation) == OP_TICK) begin
                                    r_tick  <= 1'b1;
                                    r_mi    <= '0;
                                    r_state <= S_TMR;
                                end else begin
                                    r_tick  <= 1'b0;
                                    r_ti    <= '0;
                                    r_best  <= IDLE_SLOT;
                                    r_best0 <= IDLE_SLOT;
                                    r_bpri  <= LOW_PRI;
                                    r_bpri0 <= LOW_PRI;
                                    r_state <= S_PICK;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WTASK: begin
                    if (r_in_range) begin
                        r_status[r_ti] <= r_in_state;
                        r_pri[r_ti]    <= r_in_pri;
                        r_weight[r_ti] <= r_in_weight;
                        r_budget[r_ti] <= r_in_weight;
                        r_wkind[r_ti]  <= r_in_pend;
                        r_wticks[r_ti] <= r_in_count;
                        r_tflag[r_ti]  <= 1'b0;
                    end
                    r_state <= S_ACK;
                end
                S_WTIMER: begin
                    if (r_in_range) begin
                        r_tm_status[r_mi] <= r_in_state[1:0];
                        r_tm_rep[r_mi]    <= r_in_repeat;
                        r_tm_rld[r_mi]    <= r_in_count;
                        r_tm_cnt[r_mi]    <= r_in_count;
                    end
                    r_state <= S_ACK;
                end
                S_ACK: begin
                    if (can_out) begin
                        n_ov    = 1'b1;
                        r_kind  <= RK_ACK;
                        r_idx   <= r_ack_idx;
                        r_to    <= 1'b0;
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_TMR: begin
                    logic fire;
                    fire = 1'b0;
                    if (r_tm_status[r_mi] == TM_RUN) begin
                        fire = (r_tm_rep[r_mi] == 16'd1) || (r_tm_cnt[r_mi] == 32'd0);
                    end
                    if (!fire || can_out) begin
                        if (fire) begin
                            n_ov   = 1'b1;
                            r_kind <= RK_FIRED;
                            r_idx  <= 4'(r_mi);
                            r_to   <= 1'b0;
                            r_last <= 1'b0;
                        end
                        if (r_tm_status[r_mi] == TM_RUN) begin
                            if (r_tm_rep[r_mi] == 16'd1) begin
                                r_tm_status[r_mi] <= TM_STOP;
                            end else if (r_tm_cnt[r_mi] != 32'd0) begin
                                r_tm_cnt[r_mi] <= r_tm_cnt[r_mi] - 32'd1;
                            end else begin
                                if (r_tm_rep[r_mi] != 16'd0) begin
                                    r_tm_rep[r_mi] <= r_tm_rep[r_mi] - 16'd1;
                                end
                                r_tm_cnt[r_mi] <= r_tm_rld[r_mi];
                            end
                        end
                        if (r_mi == LAST_TIMER) begin
                            r_ti    <= '0;
                            r_state <= S_TSK;
                        end else begin
                            r_mi <= r_mi + MW'(1);
                        end
                    end
                end
                S_TSK: begin
                    logic wake, tout;
                    wake = 1'b0;
                    tout = 1'b0;
                    if (r_status[r_ti] == TS_PEND) begin
                        if (r_wkind[r_ti] == PK_SLEEP) begin
                            wake = (r_wticks[r_ti] == 32'd1);
                        end else if (r_wkind[r_ti] != PK_NONE) begin
                            wake = (r_wticks[r_ti] == 32'd1);
                            tout = wake;
                        end
                    end
                    if (!wake || can_out) begin
                        if (wake) begin
                            n_ov           = 1'b1;
                            r_kind         <= RK_WOKEN;
                            r_idx          <= 4'(r_ti);
                            r_to           <= tout;
                            r_last         <= 1'b0;
                            r_status[r_ti] <= TS_READY;
                        end
                        if (tout) begin
                            r_tflag[r_ti] <= 1'b1;
                        end else if (r_status[r_ti] == TS_PEND &&
                                     r_wkind[r_ti] != PK_NONE &&
                                     r_wticks[r_ti] != 32'd0) begin
                            r_wticks[r_ti] <= r_wticks[r_ti] - 32'd1;
                        end
                        if (r_ti == LAST_TASK) begin
                            r_ti <= '0;
                            if (r_refill_cnt == r_period) begin
                                r_refill_cnt <= 16'd0;
                                r_state      <= S_RFL;
                            end else begin
                                r_refill_cnt <= r_refill_cnt + 16'd1;
                                r_best       <= IDLE_SLOT;
                                r_best0      <= IDLE_SLOT;
                                r_bpri       <= LOW_PRI;
                                r_bpri0      <= LOW_PRI;
                                r_state      <= S_PICK;
                            end
                        end else begin
                            r_ti <= r_ti + TW'(1);
                        end
                    end
                end
                S_RFL: begin
                    if (r_status[r_ti] == TS_READY || r_status[r_ti] == TS_RUN ||
                        r_status[r_ti] == TS_PEND) begin
                        r_budget[r_ti] <= r_weight[r_ti];
                    end
                    if (r_ti == LAST_TASK) begin
                        r_ti    <= '0;
                        r_best  <= IDLE_SLOT;
                        r_best0 <= IDLE_SLOT;
                        r_bpri  <= LOW_PRI;
                        r_bpri0 <= LOW_PRI;
                        r_state <= S_PICK;
                    end else begin
                        r_ti <= r_ti + TW'(1);
                    end
                end
                S_PICK: begin
                    r_best  <= n_best;
                    r_best0 <= n_best0;
                    r_bpri  <= n_bpri;
                    r_bpri0 <= n_bpri0;
                    if (r_ti == LAST_TASK) begin
                        r_nx    <= (n_best == IDLE_SLOT) ? n_best0 : n_best;
                        r_ti    <= (n_best == IDLE_SLOT) ? n_best0 : n_best;
                        r_state <= S_CH1;
                    end else begin
                        r_ti <= r_ti + TW'(1);
                    end
                end
                S_CH1: begin
                    if (r_budget[r_ti] != 16'd0) begin
                        r_budget[r_ti] <= r_budget[r_ti] - 16'd1;
                    end
                    if (r_ti == r_cur) begin
                        r_ack_idx <= 4'(r_cur);
                        r_state   <= S_ACK;
                    end else if (r_tick) begin
                        r_ti    <= r_cur;
                        r_state <= S_CH2;
                    end else begin
                        r_state <= S_CH3;
                    end
                end
                S_CH2: begin
                    if (r_status[r_ti] == TS_RUN) begin
                        r_status[r_ti] <= TS_READY;
                    end
                    r_ti    <= r_nx;
                    r_state <= S_CH3;
                end
                S_CH3: begin
                    if (can_out) begin
                        r_status[r_ti] <= TS_RUN;
                        r_cur          <= r_nx;
                        n_ov           = 1'b1;
                        r_kind         <= RK_SWITCH;
                        r_idx          <= 4'(r_nx);
                        r_to           <= 1'b0;
                        r_last         <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            r_ov <= n_ov;
        end
    end

`ifndef SYNTHESIS
    a_switch_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == RK_SWITCH |-> o_last)
        else $error("switch result not marked last");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_in_stall)
        else $error("input not stalled after a transaction was taken");

    a_timeout_only_woken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_timed_out |-> o_result_kind == RK_WOKEN)
        else $error("timeout flag on a non-wake result");

    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < TASK_SLOTS)
        else $error("current task out of range");
`endif

endmodule
